// File: sv/tsfc_pkg.sv
`default_nettype none

package tsfc_pkg;

    // Field and bus widths
    localparam int unsigned RAW_W    = 11;
    localparam int unsigned POS_W    = 12;
    localparam int unsigned SUM_W    = 15;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned THR_W    = 8;
    localparam int unsigned PROD_W   = RAW_W + POS_W;
    localparam int unsigned S_DATA_W = 32;
    localparam int unsigned S_USER_W = 1;
    localparam int unsigned M_DATA_W = 24;
    localparam int unsigned M_USER_W = 3;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned APB_W    = 32;

    // Batch handling
    localparam logic [CNT_W-1:0] BATCH_LEN   = 4'd10;
    localparam int unsigned      BATCH_SHIFT = 3;
    localparam logic [RAW_W-1:0] RAW_MAX     = 11'h7FF;

    // Register reset values
    localparam logic [POS_W-1:0] WIDTH_RST     = 12'd800;
    localparam logic [POS_W-1:0] HEIGHT_RST    = 12'd480;
    localparam logic [THR_W-1:0] THRESHOLD_RST = 8'd8;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_CALIBRATING = 3'd0;
    localparam logic [2:0] REG_CAL_MIN_X   = 3'd1;
    localparam logic [2:0] REG_CAL_MAX_X   = 3'd2;
    localparam logic [2:0] REG_CAL_MIN_Y   = 3'd3;
    localparam logic [2:0] REG_CAL_MAX_Y   = 3'd4;
    localparam logic [2:0] REG_WIDTH       = 3'd5;
    localparam logic [2:0] REG_HEIGHT      = 3'd6;
    localparam logic [2:0] REG_THRESHOLD   = 3'd7;

    // Input operations
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Event kinds
    localparam logic [1:0] EV_PRESS     = 2'd0;
    localparam logic [1:0] EV_MOVE      = 2'd1;
    localparam logic [1:0] EV_RELEASE   = 2'd2;
    localparam logic [1:0] EV_CAL_POINT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_SETUP,
        ST_MUL,
        ST_DIV,
        ST_CHECK,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// File: sv/touch_sample_filter_calibrate.sv
`default_nettype none

// Touch-panel sample filter and calibration scaler.
// Slave stream: one transfer per item. s_tuser is the operation (0 sample pair,
// 1 pen released); s_tdata carries the raw reply bytes of the X and Y conversions.
// Master stream: one transfer per press, move, release or calibration point.
// Configuration: APB-style port, eight registers at byte addresses 0x00..0x1C,
// pready tied high. They are to be written only while the block is idle, which
// the block itself does not enforce. A sample item that does not complete a
// batch of ten is only accumulated; a release with the pen down goes on to load
// the result. The tenth sample forms the trimmed averages, then per axis a setup
// step, a multiply step and the shared restoring divider, then a motion check
// and, if the position moved past the threshold, the result load; in calibration
// mode the averages become the position and nothing is emitted. The divider is
// used by X then Y. Results that saturate or scale to zero skip the divider.
// s_tready is high only in the idle state; while the output register still
// holds an untaken result the block may accept items that yield nothing, and
// an item that yields a result waits for the register to empty.
// Reset clears registers to their defaults, the batch and the pen state, and
// empties the output register. A stalled receiver holds m_tdata and m_tuser.
module touch_sample_filter_calibrate (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [7:0] x_high_byte, [15:8] x_low_byte, [23:16] y_high_byte, [31:24] y_low_byte
    input  wire logic [tsfc_pkg::S_DATA_W-1:0]   s_tdata,
    // [0] operation
    input  wire logic [tsfc_pkg::S_USER_W-1:0]   s_tuser,
    // master stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [11:0] pos_x, [23:12] pos_y
    output logic [tsfc_pkg::M_DATA_W-1:0]        m_tdata,
    // [1:0] event_kind, [2] uncalibrated
    output logic [tsfc_pkg::M_USER_W-1:0]        m_tuser,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tsfc_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [tsfc_pkg::APB_W-1:0]      pwdata,
    output logic [tsfc_pkg::APB_W-1:0]           prdata,
    output logic                                 pready
);
    import tsfc_pkg::*;

    // configuration registers
    logic             r_calibrating;
    logic [RAW_W-1:0] r_cal_min_x, r_cal_max_x, r_cal_min_y, r_cal_max_y;
    logic [POS_W-1:0] r_width, r_height;
    logic [THR_W-1:0] r_threshold;

    // batch and position state
    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] r_sum_x, r_sum_y;
    logic [RAW_W-1:0] r_low_x, r_high_x, r_low_y, r_high_y;
    logic [RAW_W-1:0] r_avg_x, r_avg_y;
    logic [POS_W-1:0] r_cur_x, r_cur_y, r_rep_x, r_rep_y;
    logic             r_pen_down;
    logic [1:0]       r_kind;

    // sequencer and shared scaling unit
    t_state           r_state, n_state;
    logic             r_axis;
    logic [RAW_W-1:0] r_num, r_den;
    logic [POS_W-1:0] r_span;
    logic [RAW_W-1:0] r_rem;
    logic [POS_W-1:0] r_dvd;
    logic [CNT_W-1:0] r_step;

    // output register
    logic              r_out_valid;
    logic [1:0]        r_out_kind;
    logic              r_out_unc;
    logic [POS_W-1:0]  r_out_x, r_out_y;

    logic             cfg_wr;
    logic [2:0]       cfg_idx;
    logic             in_acc;
    logic             in_op;
    logic [RAW_W-1:0] in_x, in_y;
    logic [CNT_W-1:0] n_count;
    logic             out_free;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = paddr[ADDR_W-1:2];
    assign s_tready = (r_state == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_op    = s_tuser[0];
    assign in_x     = {s_tdata[6:0], s_tdata[15:12]};
    assign in_y     = {s_tdata[22:16], s_tdata[31:28]};
    assign n_count  = r_count + CNT_W'(1);
    assign out_free = !r_out_valid || m_tready;

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {r_out_y, r_out_x};
    assign m_tuser  = {r_out_unc, r_out_kind};

    // register read mux
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_CALIBRATING: prdata = APB_W'(r_calibrating);
            REG_CAL_MIN_X:   prdata = APB_W'(r_cal_min_x);
            REG_CAL_MAX_X:   prdata = APB_W'(r_cal_max_x);
            REG_CAL_MIN_Y:   prdata = APB_W'(r_cal_min_y);
            REG_CAL_MAX_Y:   prdata = APB_W'(r_cal_max_y);
            REG_WIDTH:       prdata = APB_W'(r_width);
            REG_HEIGHT:      prdata = APB_W'(r_height);
            REG_THRESHOLD:   prdata = APB_W'(r_threshold);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calibrating <= 1'b0;
            r_cal_min_x   <= '0;
            r_cal_max_x   <= '0;
            r_cal_min_y   <= '0;
            r_cal_max_y   <= '0;
            r_width       <= WIDTH_RST;
            r_height      <= HEIGHT_RST;
            r_threshold   <= THRESHOLD_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_CALIBRATING: r_calibrating <= pwdata[0];
                REG_CAL_MIN_X:   r_cal_min_x   <= pwdata[RAW_W-1:0];
                REG_CAL_MAX_X:   r_cal_max_x   <= pwdata[RAW_W-1:0];
                REG_CAL_MIN_Y:   r_cal_min_y   <= pwdata[RAW_W-1:0];
                REG_CAL_MAX_Y:   r_cal_max_y   <= pwdata[RAW_W-1:0];
                REG_WIDTH:       r_width       <= pwdata[POS_W-1:0];
                REG_HEIGHT:      r_height      <= pwdata[POS_W-1:0];
                REG_THRESHOLD:   r_threshold   <= pwdata[THR_W-1:0];
                default:         r_threshold   <= r_threshold;
            endcase
        end
    end

    // Axis setup: pick operands for the axis in work, decide direction and
    // the cases that need no division.
    logic [RAW_W-1:0] ax_v, ax_lo, ax_hi, ax_num, ax_den;
    logic [POS_W-1:0] ax_span;
    logic             ax_up, ax_dn, ax_zero, ax_sat;

    always_comb begin
        ax_v    = r_axis ? r_avg_y     : r_avg_x;
        ax_lo   = r_axis ? r_cal_min_y : r_cal_min_x;
        ax_hi   = r_axis ? r_cal_max_y : r_cal_max_x;
        ax_span = r_axis ? r_height    : r_width;
        ax_up   = ax_hi > ax_lo;
        ax_dn   = ax_lo > ax_hi;
        ax_num  = ax_up ? (ax_v - ax_lo) : (ax_lo - ax_v);
        ax_den  = ax_up ? (ax_hi - ax_lo) : (ax_lo - ax_hi);
        ax_zero = !(ax_up || ax_dn) || (ax_up && (ax_v <= ax_lo)) ||
                  (ax_dn && (ax_v >= ax_lo));
        ax_sat  = ax_num >= ax_den;
    end

    // Divider step: bring down one dividend bit, subtract if it fits.
    logic [RAW_W:0]   div_t;
    logic             div_ge;
    logic [RAW_W:0]   div_diff;
    logic [PROD_W-1:0] mul_p;

    always_comb begin
        div_t    = {r_rem, r_dvd[POS_W-1]};
        div_ge   = div_t >= {1'b0, r_den};
        div_diff = div_t - {1'b0, r_den};
        mul_p    = PROD_W'(r_num) * PROD_W'(r_span);
    end

    // Motion check
    logic [POS_W-1:0] dx, dy;
    logic             moved;

    always_comb begin
        dx    = (r_rep_x > r_cur_x) ? (r_rep_x - r_cur_x) : (r_cur_x - r_rep_x);
        dy    = (r_rep_y > r_cur_y) ? (r_rep_y - r_cur_y) : (r_cur_y - r_rep_y);
        moved = (dx > POS_W'(r_threshold)) || (dy > POS_W'(r_threshold));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_op == OP_RELEASE) begin
                        n_state = r_pen_down ? ST_EMIT : ST_IDLE;
                    end else if (n_count == BATCH_LEN) begin
                        n_state = ST_AVG;
                    end
                end
            end
            ST_AVG:   n_state = r_calibrating ? ST_IDLE : ST_SETUP;
            ST_SETUP: begin
                if (ax_zero || ax_sat) begin
                    n_state = r_axis ? ST_CHECK : ST_SETUP;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:   n_state = ST_DIV;
            ST_DIV: begin
                if (r_step == CNT_W'(POS_W - 1)) begin
                    n_state = r_axis ? ST_CHECK : ST_SETUP;
                end
            end
            ST_CHECK: n_state = moved ? ST_EMIT : ST_IDLE;
            ST_EMIT:  n_state = out_free ? ST_IDLE : ST_EMIT;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control strobes
    logic do_sample, do_release, do_avg, do_store, do_emit;
    logic [POS_W-1:0] store_val;

    always_comb begin
        do_sample  = (r_state == ST_IDLE) && in_acc && (in_op == OP_SAMPLE);
        do_release = (r_state == ST_IDLE) && in_acc && (in_op == OP_RELEASE);
        do_avg     = (r_state == ST_AVG);
        do_emit    = (r_state == ST_EMIT) && out_free;
        do_store   = 1'b0;
        store_val  = '0;
        if (r_state == ST_SETUP && (ax_zero || ax_sat)) begin
            do_store  = 1'b1;
            store_val = ax_zero ? '0 : ax_span;
        end else if (r_state == ST_DIV && r_step == CNT_W'(POS_W - 1)) begin
            do_store  = 1'b1;
            store_val = {r_dvd[POS_W-2:0], div_ge};
        end
    end

    // Trimmed batch average: drop extremes, divide by eight.
    function automatic logic [RAW_W-1:0] r_avg_x_next(
        input logic [SUM_W-1:0] sum,
        input logic [RAW_W-1:0] lo,
        input logic [RAW_W-1:0] hi
    );
        logic [SUM_W-1:0] trimmed;
        trimmed = sum - SUM_W'(lo) - SUM_W'(hi);
        return trimmed[BATCH_SHIFT +: RAW_W];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_sum_x    <= '0;
            r_sum_y    <= '0;
            r_low_x    <= RAW_MAX;
            r_high_x   <= '0;
            r_low_y    <= RAW_MAX;
            r_high_y   <= '0;
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_rep_x    <= '0;
            r_rep_y    <= '0;
            r_pen_down <= 1'b0;
            r_kind     <= EV_PRESS;
            r_axis     <= 1'b0;
            r_step     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // accumulate, or drop the batch on release and after averaging
            if (do_sample) begin
                r_count <= n_count;
                r_sum_x <= r_sum_x + SUM_W'(in_x);
                r_sum_y <= r_sum_y + SUM_W'(in_y);
                if (in_x < r_low_x)  r_low_x  <= in_x;
                if (in_x > r_high_x) r_high_x <= in_x;
                if (in_y < r_low_y)  r_low_y  <= in_y;
                if (in_y > r_high_y) r_high_y <= in_y;
            end else if (do_release || do_avg) begin
                r_count  <= '0;
                r_sum_x  <= '0;
                r_sum_y  <= '0;
                r_low_x  <= RAW_MAX;
                r_high_x <= '0;
                r_low_y  <= RAW_MAX;
                r_high_y <= '0;
            end

            if (do_release) begin
                r_kind     <= r_calibrating ? EV_CAL_POINT : EV_RELEASE;
                r_rep_x    <= '0;
                r_rep_y    <= '0;
                r_pen_down <= 1'b0;
            end

            if (do_avg) begin
                r_axis <= 1'b0;
                if (r_calibrating) begin
                    r_cur_x    <= POS_W'(r_avg_x_next(r_sum_x, r_low_x, r_high_x));
                    r_cur_y    <= POS_W'(r_avg_x_next(r_sum_y, r_low_y, r_high_y));
                    r_pen_down <= 1'b1;
                end
            end

            if (r_state == ST_MUL) begin
                r_rem  <= mul_p[PROD_W-1:POS_W];
                r_dvd  <= mul_p[POS_W-1:0];
                r_step <= '0;
            end

            if (r_state == ST_DIV) begin
                r_rem  <= div_ge ? div_diff[RAW_W-1:0] : div_t[RAW_W-1:0];
                r_dvd  <= {r_dvd[POS_W-2:0], div_ge};
                r_step <= r_step + CNT_W'(1);
            end

            if (do_store) begin
                if (r_axis) r_cur_y <= store_val;
                else        r_cur_x <= store_val;
                r_axis <= 1'b1;
            end

            if (r_state == ST_CHECK && moved) begin
                r_kind     <= r_pen_down ? EV_MOVE : EV_PRESS;
                r_rep_x    <= r_cur_x;
                r_rep_y    <= r_cur_y;
                r_pen_down <= 1'b1;
            end

            // output register: drop when taken, load from the emit state
            if (do_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (do_avg) begin
            r_avg_x <= r_avg_x_next(r_sum_x, r_low_x, r_high_x);
            r_avg_y <= r_avg_x_next(r_sum_y, r_low_y, r_high_y);
        end
        if (r_state == ST_SETUP) begin
            r_num  <= ax_num;
            r_den  <= ax_den;
            r_span <= ax_span;
        end
        if (do_emit) begin
            r_out_kind <= r_kind;
            r_out_x    <= r_cur_x;
            r_out_y    <= r_cur_y;
            r_out_unc  <= !r_calibrating &&
                          ((r_cal_min_x == r_cal_max_x) || (r_cal_min_y == r_cal_max_y));
        end
    end

endmodule

`default_nettype wire
